### rtl/swrc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the sensor word
// response checker. Used by swrc_core and sensor_word_response_checker.
package swrc_pkg;

    localparam int unsigned KindWidth   = 2;
    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned WordWidth   = 16;
    localparam int unsigned StatusWidth = 2;
    localparam int unsigned PosWidth    = 3;

    localparam logic [ByteWidth-1:0] CrcPoly      = 8'h31;
    localparam logic [ByteWidth-1:0] CrcInit      = 8'hFF;
    localparam logic [WordWidth-1:0] SelftestPass = 16'hD400;
    localparam logic [WordWidth-1:0] WarmupCo2    = 16'd400;

    localparam logic [PosWidth-1:0] SelftestLen = 3'd3;
    localparam logic [PosWidth-1:0] MeasureLen  = 3'd6;

    typedef enum logic [KindWidth-1:0] {
        KIND_INIT     = 2'd0,
        KIND_SELFTEST = 2'd1,
        KIND_MEASURE  = 2'd2
    } t_kind;

    typedef enum logic [StatusWidth-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CRC_FAIL = 2'd1,
        STATUS_MISMATCH = 2'd2,
        STATUS_INIT     = 2'd3
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [WordWidth-1:0]  first_word;
        logic [WordWidth-1:0]  second_word;
    } t_result;

    // Bitwise MSB-first CRC-8 update over one byte, no reflection.
    function automatic logic [ByteWidth-1:0] crc_update(
        input logic [ByteWidth-1:0] crc,
        input logic [ByteWidth-1:0] b
    );
        logic [ByteWidth-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < ByteWidth; k++) begin
            if (c[ByteWidth-1]) begin
                c = {c[ByteWidth-2:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[ByteWidth-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/swrc_core.sv
// Frame state for the sensor word response checker: byte position, running
// CRC, word holds and warm-up flag. Depends on swrc_pkg.
module swrc_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_take,
    input  logic [swrc_pkg::KindWidth-1:0]      i_command_kind,
    input  logic [swrc_pkg::ByteWidth-1:0]      i_data_byte,
    input  logic                                i_frame_start,
    output logic                                o_res_valid,
    output swrc_pkg::t_result                   o_res
);

    logic [swrc_pkg::PosWidth-1:0]  r_pos,   n_pos;
    logic [swrc_pkg::ByteWidth-1:0] r_crc,   n_crc;
    logic [swrc_pkg::ByteWidth-1:0] r_high,  n_high;
    logic [swrc_pkg::ByteWidth-1:0] r_low,   n_low;
    logic [swrc_pkg::WordWidth-1:0] r_first, n_first;
    logic                           r_err,   n_err;
    logic                           r_warm,  n_warm;

    logic [swrc_pkg::PosWidth-1:0]  pos;
    logic [swrc_pkg::PosWidth-1:0]  len;
    logic [swrc_pkg::ByteWidth-1:0] crc;
    logic                           err;
    logic [1:0]                     slot;
    logic [swrc_pkg::WordWidth-1:0] w2;
    logic                           is_frame;

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_high      = r_high;
        n_low       = r_low;
        n_first     = r_first;
        n_err       = r_err;
        n_warm      = r_warm;
        o_res_valid = 1'b0;
        o_res       = '0;
        is_frame    = (i_command_kind == swrc_pkg::KIND_SELFTEST) ||
                      (i_command_kind == swrc_pkg::KIND_MEASURE);
        pos  = i_frame_start ? '0 : r_pos;
        crc  = i_frame_start ? swrc_pkg::CrcInit : r_crc;
        err  = i_frame_start ? 1'b0 : r_err;
        len  = (i_command_kind == swrc_pkg::KIND_SELFTEST) ?
               swrc_pkg::SelftestLen : swrc_pkg::MeasureLen;
        unique case (pos)
            3'd0, 3'd3: slot = 2'd0;
            3'd1, 3'd4: slot = 2'd1;
            3'd2, 3'd5: slot = 2'd2;
            default:    slot = 2'd0;
        endcase
        w2 = '0;

        if (i_take && i_command_kind == swrc_pkg::KIND_INIT) begin
            n_warm = 1'b1;
        end else if (i_take && is_frame) begin
            n_pos = pos;
            n_crc = crc;
            n_err = err;
            if (pos < len) begin
                unique case (slot)
                    2'd0: begin
                        n_high = i_data_byte;
                        n_crc  = swrc_pkg::crc_update(crc, i_data_byte);
                    end
                    2'd1: begin
                        n_low = i_data_byte;
                        n_crc = swrc_pkg::crc_update(crc, i_data_byte);
                        if (pos == 3'd1) begin
                            n_first = {r_high, i_data_byte};
                        end
                    end
                    default: begin
                        if (crc != i_data_byte) begin
                            n_err = 1'b1;
                        end
                        n_crc = swrc_pkg::CrcInit;
                    end
                endcase
                n_pos = pos + 3'd1;

                // Report on the last byte of the response.
                if (pos == len - 3'd1) begin
                    o_res_valid = 1'b1;
                    w2 = {n_high, n_low};
                    if (n_err) begin
                        o_res.status = swrc_pkg::STATUS_CRC_FAIL;
                    end else if (i_command_kind == swrc_pkg::KIND_SELFTEST) begin
                        o_res.status     = (n_first == swrc_pkg::SelftestPass) ?
                                           swrc_pkg::STATUS_OK :
                                           swrc_pkg::STATUS_MISMATCH;
                        o_res.first_word = n_first;
                    end else begin
                        if (r_warm && n_first == swrc_pkg::WarmupCo2 && w2 == '0) begin
                            o_res.status = swrc_pkg::STATUS_INIT;
                        end else begin
                            o_res.status = swrc_pkg::STATUS_OK;
                            n_warm       = 1'b0;
                        end
                        o_res.first_word  = n_first;
                        o_res.second_word = w2;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_crc   <= swrc_pkg::CrcInit;
            r_high  <= '0;
            r_low   <= '0;
            r_first <= '0;
            r_err   <= 1'b0;
            r_warm  <= 1'b1;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_high  <= n_high;
            r_low   <= n_low;
            r_first <= n_first;
            r_err   <= n_err;
            r_warm  <= n_warm;
        end
    end

endmodule

### rtl/sensor_word_response_checker.sv
// Top level of the sensor word response checker: frame core plus a
// registered result stage with one skid entry. Depends on swrc_pkg, swrc_core.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one item per unstalled cycle: a
//   response byte of a self-test or measurement, or an init event. Each 16-bit
//   word is followed by its CRC-8 (poly 0x31, init 0xFF) and checked on arrival.
//   Output channel (o_valid / i_stall) carries one result at the end of each
//   response: status, first word, second word.
//   Throughput: one item per cycle while o_stall is low; the CRC byte update
//   is unrolled, so the frame state loop closes combinationally.
//   Result path: the result for the last accepted byte of a response is
//   registered into the output register, or into the skid entry if stalled.
//   Stall: while the receiver stalls, one more result is held in the skid
//   entry; o_stall rises only once that entry is occupied.
//   Reset: synchronous, active low; clears both result entries, restarts the
//   frame state and sets the warm-up flag. No clearing pass is needed.
module sensor_word_response_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [swrc_pkg::KindWidth-1:0]      i_command_kind,
    input  logic [swrc_pkg::ByteWidth-1:0]      i_data_byte,
    input  logic                                i_frame_start,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [swrc_pkg::StatusWidth-1:0]    o_status,
    output logic [swrc_pkg::WordWidth-1:0]      o_first_word,
    output logic [swrc_pkg::WordWidth-1:0]      o_second_word
);

    logic              take;
    logic              pop;
    logic              res_valid;
    swrc_pkg::t_result res;

    logic              r_out_valid, n_out_valid;
    swrc_pkg::t_result r_out,       n_out;
    logic              r_skid_valid, n_skid_valid;
    swrc_pkg::t_result r_skid,       n_skid;

    assign take = i_valid && !r_skid_valid;
    assign pop  = r_out_valid && !i_stall;

    swrc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_command_kind (i_command_kind),
        .i_data_byte    (i_data_byte),
        .i_frame_start  (i_frame_start),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // No item is taken here; drain the skid entry.
            if (pop) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            n_out_valid = take && res_valid;
            n_out       = res;
        end else if (take && res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_stall       = r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_first_word  = r_out.first_word;
    assign o_second_word = r_out.second_word;

    // The skid entry is only filled behind a held output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry occupied with empty output register");

    // A drained skid entry moves to the output and frees the input side.
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (o_valid && !o_stall))
        else $error("skid entry did not drain into output register");

    // Init events and unused kinds never produce a result.
    a_no_result_non_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_command_kind != swrc_pkg::KIND_SELFTEST &&
         i_command_kind != swrc_pkg::KIND_MEASURE) |-> !res_valid)
        else $error("result produced for a non-frame item");

endmodule
